/* rtl/alse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alse_pkg
// Shared types and constants for the array list search and edit unit.
// ----------------------------------------------------------------------------
package alse_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      CMD_FIND   = 2'd0,
      CMD_MODIFY = 2'd1,
      CMD_APPEND = 2'd2,
      CMD_DELETE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_BAD_INDEX = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DEL,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type                status;
      logic [ADDR_W-1:0]         position;
      logic signed [DATA_W-1:0]  old_value;
      logic signed [DATA_W-1:0]  new_value;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

endpackage

/* rtl/alse_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alse_req_if
// Request channel: valid/ready handshake carrying one list command.
// ----------------------------------------------------------------------------
interface alse_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        cmd;
   logic signed [alse_pkg::DATA_W-1:0] value;
   logic [alse_pkg::ADDR_W-1:0]        index;

   modport source (output valid, output cmd, output value, output index, input ready);
   modport sink   (input valid, input cmd, input value, input index, output ready);
endinterface

/* rtl/alse_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alse_rsp_if
// Response channel: valid/ready handshake carrying one command result.
// ----------------------------------------------------------------------------
interface alse_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic [alse_pkg::ADDR_W-1:0]        position;
   logic signed [alse_pkg::DATA_W-1:0] old_value;
   logic signed [alse_pkg::DATA_W-1:0] new_value;
   logic [alse_pkg::COUNT_W-1:0]       count;

   modport source (output valid, output status, output position, output old_value,
                   output new_value, output count, input ready);
   modport sink   (input valid, input status, input position, input old_value,
                   input new_value, input count, output ready);
endinterface

/* rtl/array_list_search_edit_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_search_edit_unit
// Unordered list of signed 32-bit values kept in one synchronous RAM.
//
// One request (find, modify by ten, append, delete at index) enters on
// req_if and gives exactly one response on rsp_if. Requests are handled one
// at a time; req_if.ready is high while the sequencer is idle.
// Find and modify scan the RAM one entry per cycle with a pipelined read.
// Delete shifts the tail down with one read and one write per cycle.
// Append and the failing checks (full store, bad index) go from idle
// straight to the done state.
// The response sits in an output register, so a new request is taken while
// an older response still waits; if the receiver stalls and a second result
// is ready, the sequencer holds it and accepts nothing more until rsp_if
// drains. Reset (synchronous) empties the list and drops any pending
// response; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module array_list_search_edit_unit (
   input  logic       clock,
   input  logic       reset,
   alse_req_if.sink   req_if,
   alse_rsp_if.source rsp_if
);

   alse_pkg::state_type state_ff, state_in;

   logic [alse_pkg::COUNT_W-1:0]       count_ff, count_in;
   alse_pkg::cmd_type                  cmd_ff, cmd_in;
   logic signed [alse_pkg::DATA_W-1:0] value_ff, value_in;
   logic [alse_pkg::ADDR_W-1:0]        idx_ff, idx_in;
   logic [alse_pkg::COUNT_W-1:0]       issue_ff, issue_in;
   logic                               pend_v_ff, pend_v_in;
   logic [alse_pkg::ADDR_W-1:0]        pend_a_ff, pend_a_in;
   alse_pkg::rsp_type                  res_ff, res_in;
   alse_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic [alse_pkg::DATA_W-1:0] mem [alse_pkg::CAPACITY];
   logic [alse_pkg::DATA_W-1:0] mem_q;
   logic                        mem_we, mem_re;
   logic [alse_pkg::ADDR_W-1:0] mem_wa, mem_ra;
   logic [alse_pkg::DATA_W-1:0] mem_wd;

   logic                        hit;
   logic                        more;
   logic                        out_free;
   logic [alse_pkg::DATA_W-1:0] times_ten;

   assign hit       = pend_v_ff && (mem_q == value_ff);
   assign more      = issue_ff < count_ff;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign times_ten = (mem_q << 3) + (mem_q << 1);

   assign req_if.ready     = (state_ff == alse_pkg::S_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_ff.status;
   assign rsp_if.position  = rsp_ff.position;
   assign rsp_if.old_value = rsp_ff.old_value;
   assign rsp_if.new_value = rsp_ff.new_value;
   assign rsp_if.count     = rsp_ff.count;

   // entry storage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q <= mem[mem_ra];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         alse_pkg::S_IDLE: begin
            if (req_if.valid) begin
               case (alse_pkg::cmd_type'(req_if.cmd))
                  alse_pkg::CMD_FIND,
                  alse_pkg::CMD_MODIFY: state_in = alse_pkg::S_SCAN;
                  alse_pkg::CMD_DELETE: begin
                     if ({1'b0, req_if.index} < count_ff) begin
                        state_in = alse_pkg::S_DEL;
                     end else begin
                        state_in = alse_pkg::S_DONE;
                     end
                  end
                  default: state_in = alse_pkg::S_DONE;
               endcase
            end
         end
         alse_pkg::S_SCAN: begin
            if (hit || (!pend_v_ff && !more)) begin
               state_in = alse_pkg::S_DONE;
            end
         end
         alse_pkg::S_DEL: begin
            if (!pend_v_ff && !more) begin
               state_in = alse_pkg::S_DONE;
            end
         end
         alse_pkg::S_DONE: begin
            if (out_free) begin
               state_in = alse_pkg::S_IDLE;
            end
         end
         default: state_in = alse_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      pend_v_in    = pend_v_ff;
      pend_a_in    = pend_a_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      mem_re       = 1'b0;
      mem_ra       = '0;

      case (state_ff)
         alse_pkg::S_IDLE: begin
            if (req_if.valid) begin
               cmd_in    = alse_pkg::cmd_type'(req_if.cmd);
               value_in  = req_if.value;
               idx_in    = req_if.index;
               pend_v_in = 1'b0;
               res_in    = '{status: alse_pkg::ST_OK, position: '0, old_value: '0,
                             new_value: '0, count: count_ff};
               case (alse_pkg::cmd_type'(req_if.cmd))
                  alse_pkg::CMD_FIND,
                  alse_pkg::CMD_MODIFY: issue_in = '0;
                  alse_pkg::CMD_DELETE: begin
                     issue_in = {1'b0, req_if.index};
                     if ({1'b0, req_if.index} >= count_ff) begin
                        res_in.status = alse_pkg::ST_BAD_INDEX;
                     end
                  end
                  default: begin
                     if (count_ff >= alse_pkg::COUNT_W'(alse_pkg::CAPACITY)) begin
                        res_in.status = alse_pkg::ST_FULL;
                     end else begin
                        mem_we           = 1'b1;
                        mem_wa           = count_ff[alse_pkg::ADDR_W-1:0];
                        mem_wd           = req_if.value;
                        res_in.position  = count_ff[alse_pkg::ADDR_W-1:0];
                        res_in.new_value = req_if.value;
                        res_in.count     = count_ff + 1'b1;
                        count_in         = count_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         alse_pkg::S_SCAN: begin
            if (hit) begin
               res_in.status    = alse_pkg::ST_OK;
               res_in.position  = pend_a_ff;
               res_in.old_value = mem_q;
               if (cmd_ff == alse_pkg::CMD_MODIFY) begin
                  res_in.new_value = times_ten;
                  mem_we           = 1'b1;
                  mem_wa           = pend_a_ff;
                  mem_wd           = times_ten;
               end else begin
                  res_in.new_value = mem_q;
               end
            end else if (more) begin
               mem_re    = 1'b1;
               mem_ra    = issue_ff[alse_pkg::ADDR_W-1:0];
               pend_v_in = 1'b1;
               pend_a_in = issue_ff[alse_pkg::ADDR_W-1:0];
               issue_in  = issue_ff + 1'b1;
            end else if (pend_v_ff) begin
               pend_v_in = 1'b0;
            end else begin
               res_in.status = alse_pkg::ST_NOT_FOUND;
            end
         end
         alse_pkg::S_DEL: begin
            // first read returns the removed entry, later ones move down one slot
            if (pend_v_ff) begin
               if (pend_a_ff == idx_ff) begin
                  res_in.old_value = mem_q;
               end else begin
                  mem_we = 1'b1;
                  mem_wa = pend_a_ff - 1'b1;
                  mem_wd = mem_q;
               end
            end
            if (more) begin
               mem_re    = 1'b1;
               mem_ra    = issue_ff[alse_pkg::ADDR_W-1:0];
               pend_v_in = 1'b1;
               pend_a_in = issue_ff[alse_pkg::ADDR_W-1:0];
               issue_in  = issue_ff + 1'b1;
            end else begin
               pend_v_in = 1'b0;
               if (!pend_v_ff) begin
                  res_in.status   = alse_pkg::ST_OK;
                  res_in.position = idx_ff;
                  res_in.count    = count_ff - 1'b1;
                  count_in        = count_ff - 1'b1;
               end
            end
         end
         alse_pkg::S_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alse_pkg::S_IDLE;
         count_ff     <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      issue_ff  <= issue_in;
      pend_a_ff <= pend_a_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

endmodule

/* dv/tb_array_list_search_edit_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_list_search_edit_unit
// Self-checking bench for the array list search and edit unit. A short table
// of directed requests (empty list, extreme values, duplicates, wrap on
// modify, bad delete indexes) is followed by random traffic. The random part
// fills the list to capacity and shrinks it again. Every response is compared
// field by field with the table or shadow list. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_array_list_search_edit_unit;

   localparam int DIR_ROWS     = 24;
   localparam int MIXED_ITEMS  = 250;
   localparam int SHRINK_ITEMS = 150;
   localparam int DRAIN_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 1500000;

   typedef struct packed {
      alse_pkg::cmd_type                  cmd;
      logic signed [alse_pkg::DATA_W-1:0] value;
      logic [alse_pkg::ADDR_W-1:0]        index;
      logic                               typed;
      alse_pkg::rsp_type                  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   alse_req_if req_bus ();
   alse_rsp_if rsp_bus ();

   array_list_search_edit_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the list
   logic signed [alse_pkg::DATA_W-1:0] shadow_entries [alse_pkg::CAPACITY];
   int                                 shadow_count;

   alse_pkg::rsp_type pending_results [$];
   stim_row_type      directed_rows [DIR_ROWS];

   int errors = 0;
   int cycle_count = 0;
   int req_burst_left = 0;
   int rsp_burst_left = 0;
   int rsp_stall_left = 0;
   int cmd_seen [4];
   int status_seen [4];
   int peak_count = 0;

   function automatic int idle_length(inout int burst_left);
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(49) == 0) begin
         burst_left = 30;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic alse_pkg::rsp_type predict_list_command(
      alse_pkg::cmd_type c, logic signed [alse_pkg::DATA_W-1:0] v,
      logic [alse_pkg::ADDR_W-1:0] idx);
      alse_pkg::rsp_type res;
      int                hit;
      res = '0;
      res.status = alse_pkg::ST_OK;
      hit = -1;
      if (c == alse_pkg::CMD_FIND || c == alse_pkg::CMD_MODIFY) begin
         for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_entries[i] == v) hit = i;
         end
      end
      case (c)
         alse_pkg::CMD_FIND, alse_pkg::CMD_MODIFY: begin
            if (hit < 0) begin
               res.status = alse_pkg::ST_NOT_FOUND;
            end else begin
               res.position  = alse_pkg::ADDR_W'(hit);
               res.old_value = shadow_entries[hit];
               if (c == alse_pkg::CMD_MODIFY) begin
                  // 32-bit product, wraps
                  shadow_entries[hit] = shadow_entries[hit] * 32'sd10;
               end
               res.new_value = shadow_entries[hit];
            end
         end
         alse_pkg::CMD_APPEND: begin
            if (shadow_count >= alse_pkg::CAPACITY) begin
               res.status = alse_pkg::ST_FULL;
            end else begin
               res.position = alse_pkg::ADDR_W'(shadow_count);
               res.new_value = v;
               shadow_entries[shadow_count] = v;
               shadow_count++;
            end
         end
         default: begin
            if (int'(idx) >= shadow_count) begin
               res.status = alse_pkg::ST_BAD_INDEX;
            end else begin
               res.position  = idx;
               res.old_value = shadow_entries[idx];
               for (int i = int'(idx); i + 1 < shadow_count; i++) begin
                  shadow_entries[i] = shadow_entries[i + 1];
               end
               shadow_count--;
            end
         end
      endcase
      res.count = alse_pkg::COUNT_W'(shadow_count);
      return res;
   endfunction

   function automatic logic signed [alse_pkg::DATA_W-1:0] pick_value(bit prefer_existing);
      int r;
      if (prefer_existing && shadow_count > 0 && $urandom_range(99) < 80) begin
         return shadow_entries[$urandom_range(shadow_count - 1)];
      end
      r = $urandom_range(99);
      if (r < 15) begin
         case ($urandom_range(3))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      if (r < 40) return $signed($urandom_range(40)) - 32'sd20;
      return $signed($urandom());
   endfunction

   function automatic logic [alse_pkg::ADDR_W-1:0] pick_index();
      if (shadow_count > 0 && $urandom_range(99) < 80) begin
         return alse_pkg::ADDR_W'($urandom_range(shadow_count - 1));
      end
      return alse_pkg::ADDR_W'($urandom_range(255));
   endfunction

   task automatic send_request(alse_pkg::cmd_type c, logic signed [alse_pkg::DATA_W-1:0] v,
                               logic [alse_pkg::ADDR_W-1:0] idx,
                               logic typed, alse_pkg::rsp_type typed_want);
      int                gap;
      alse_pkg::rsp_type predicted;
      gap = idle_length(req_burst_left);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= c;
      req_bus.value <= v;
      req_bus.index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_list_command(c, v, idx);
      pending_results.push_back(typed ? typed_want : predicted);
      cmd_seen[int'(c)]++;
      status_seen[int'(predicted.status)]++;
      if (shadow_count > peak_count) peak_count = shadow_count;
   endtask

   task automatic random_request(int high_water);
      int r;
      int append_weight;
      r = $urandom_range(99);
      append_weight = (shadow_count < high_water) ? 35 : 10;
      if (r < append_weight) begin
         send_request(alse_pkg::CMD_APPEND, pick_value(1'b0),
                      alse_pkg::ADDR_W'($urandom_range(255)), 1'b0, '0);
      end else if (r < append_weight + 25) begin
         send_request(alse_pkg::CMD_FIND, pick_value(1'b1),
                      alse_pkg::ADDR_W'($urandom_range(255)), 1'b0, '0);
      end else if (r < append_weight + 45) begin
         send_request(alse_pkg::CMD_MODIFY, pick_value(1'b1),
                      alse_pkg::ADDR_W'($urandom_range(255)), 1'b0, '0);
      end else begin
         send_request(alse_pkg::CMD_DELETE, pick_value(1'b0), pick_index(), 1'b0, '0);
      end
   endtask

   // hold the sender until every response is back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic check_field(string name, logic [alse_pkg::DATA_W-1:0] want_v,
                              logic [alse_pkg::DATA_W-1:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      end
   endtask

   // response side: check accepted responses, then schedule ready
   always @(posedge clock) begin : rsp_side
      alse_pkg::rsp_type want;
      cycle_count++;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: response with no request outstanding, status %0d count %0d",
                     $time, rsp_bus.status, rsp_bus.count);
         end else begin
            want = pending_results.pop_front();
            check_field("status", alse_pkg::DATA_W'(want.status),
                        alse_pkg::DATA_W'(rsp_bus.status));
            check_field("position", alse_pkg::DATA_W'(want.position),
                        alse_pkg::DATA_W'(rsp_bus.position));
            check_field("old_value", want.old_value, rsp_bus.old_value);
            check_field("new_value", want.new_value, rsp_bus.new_value);
            check_field("count", alse_pkg::DATA_W'(want.count),
                        alse_pkg::DATA_W'(rsp_bus.count));
         end
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_stall_left = idle_length(rsp_burst_left);
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_results.size());
      $display("tb_array_list_search_edit_unit: FAIL");
      $finish;
   end

   initial begin : stimulus
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= alse_pkg::CMD_FIND;
      req_bus.value <= '0;
      req_bus.index <= '0;
      shadow_count = 0;
      for (int i = 0; i < alse_pkg::CAPACITY; i++) shadow_entries[i] = '0;
      for (int i = 0; i < 4; i++) begin
         cmd_seen[i] = 0;
         status_seen[i] = 0;
      end

      // empty list, extremes, duplicates, wrap on modify, bad and edge deletes
      directed_rows[0]  = '{alse_pkg::CMD_FIND, 32'sd0, 8'd0, 1'b1,
                            '{alse_pkg::ST_NOT_FOUND, 8'd0, 32'sd0, 32'sd0, 9'd0}};
      directed_rows[1]  = '{alse_pkg::CMD_MODIFY, 32'sd5, 8'd255, 1'b1,
                            '{alse_pkg::ST_NOT_FOUND, 8'd0, 32'sd0, 32'sd0, 9'd0}};
      directed_rows[2]  = '{alse_pkg::CMD_DELETE, 32'sd0, 8'd0, 1'b1,
                            '{alse_pkg::ST_BAD_INDEX, 8'd0, 32'sd0, 32'sd0, 9'd0}};
      directed_rows[3]  = '{alse_pkg::CMD_APPEND, 32'sh80000000, 8'd0, 1'b1,
                            '{alse_pkg::ST_OK, 8'd0, 32'sd0, 32'sh80000000, 9'd1}};
      directed_rows[4]  = '{alse_pkg::CMD_APPEND, 32'sh7fffffff, 8'd255, 1'b1,
                            '{alse_pkg::ST_OK, 8'd1, 32'sd0, 32'sh7fffffff, 9'd2}};
      directed_rows[5]  = '{alse_pkg::CMD_APPEND, 32'sd0, 8'd0, 1'b1,
                            '{alse_pkg::ST_OK, 8'd2, 32'sd0, 32'sd0, 9'd3}};
      directed_rows[6]  = '{alse_pkg::CMD_APPEND, -32'sd1, 8'd0, 1'b1,
                            '{alse_pkg::ST_OK, 8'd3, 32'sd0, -32'sd1, 9'd4}};
      directed_rows[7]  = '{alse_pkg::CMD_APPEND, 32'sd7, 8'd0, 1'b1,
                            '{alse_pkg::ST_OK, 8'd4, 32'sd0, 32'sd7, 9'd5}};
      directed_rows[8]  = '{alse_pkg::CMD_APPEND, 32'sd7, 8'd0, 1'b1,
                            '{alse_pkg::ST_OK, 8'd5, 32'sd0, 32'sd7, 9'd6}};
      directed_rows[9]  = '{alse_pkg::CMD_FIND, 32'sd7, 8'd0, 1'b0, '0};
      directed_rows[10] = '{alse_pkg::CMD_MODIFY, 32'sd7, 8'd0, 1'b0, '0};
      directed_rows[11] = '{alse_pkg::CMD_FIND, 32'sd7, 8'd0, 1'b0, '0};
      directed_rows[12] = '{alse_pkg::CMD_MODIFY, 32'sh7fffffff, 8'd0, 1'b0, '0};
      directed_rows[13] = '{alse_pkg::CMD_MODIFY, 32'sh80000000, 8'd0, 1'b0, '0};
      directed_rows[14] = '{alse_pkg::CMD_FIND, 32'sd0, 8'd0, 1'b0, '0};
      directed_rows[15] = '{alse_pkg::CMD_MODIFY, -32'sd1, 8'd0, 1'b0, '0};
      directed_rows[16] = '{alse_pkg::CMD_FIND, -32'sd10, 8'd0, 1'b0, '0};
      directed_rows[17] = '{alse_pkg::CMD_DELETE, 32'sd0, 8'd6, 1'b1,
                            '{alse_pkg::ST_BAD_INDEX, 8'd0, 32'sd0, 32'sd0, 9'd6}};
      directed_rows[18] = '{alse_pkg::CMD_DELETE, -32'sd1, 8'd255, 1'b1,
                            '{alse_pkg::ST_BAD_INDEX, 8'd0, 32'sd0, 32'sd0, 9'd6}};
      directed_rows[19] = '{alse_pkg::CMD_DELETE, 32'sd0, 8'd5, 1'b0, '0};
      directed_rows[20] = '{alse_pkg::CMD_DELETE, 32'sd0, 8'd0, 1'b0, '0};
      directed_rows[21] = '{alse_pkg::CMD_FIND, 32'sd70, 8'd0, 1'b0, '0};
      directed_rows[22] = '{alse_pkg::CMD_DELETE, 32'sd0, 8'd1, 1'b0, '0};
      directed_rows[23] = '{alse_pkg::CMD_FIND, 32'sd12345, 8'd0, 1'b0, '0};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_request(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].index,
                      directed_rows[i].typed, directed_rows[i].want);
      end
      drain_results();

      // small lists, mixed commands
      for (int i = 0; i < MIXED_ITEMS; i++) random_request(32);
      drain_results();

      // fill to capacity with a few finds mixed in
      while (shadow_count < alse_pkg::CAPACITY) begin
         if ($urandom_range(9) == 0) begin
            send_request(alse_pkg::CMD_FIND, pick_value(1'b1),
                         alse_pkg::ADDR_W'($urandom_range(255)), 1'b0, '0);
         end else begin
            send_request(alse_pkg::CMD_APPEND, pick_value(1'b0),
                         alse_pkg::ADDR_W'($urandom_range(255)), 1'b0, '0);
         end
      end
      repeat (3) send_request(alse_pkg::CMD_APPEND, pick_value(1'b0), 8'd0, 1'b0, '0);
      send_request(alse_pkg::CMD_FIND, shadow_entries[alse_pkg::CAPACITY - 1], 8'd0,
                   1'b0, '0);
      send_request(alse_pkg::CMD_MODIFY, shadow_entries[alse_pkg::CAPACITY - 1], 8'd0,
                   1'b0, '0);
      send_request(alse_pkg::CMD_DELETE, 32'sd0, 8'd255, 1'b0, '0);
      send_request(alse_pkg::CMD_APPEND, pick_value(1'b0), 8'd0, 1'b0, '0);
      send_request(alse_pkg::CMD_APPEND, pick_value(1'b0), 8'd0, 1'b0, '0);
      send_request(alse_pkg::CMD_DELETE, 32'sd0, 8'd0, 1'b0, '0);

      // large list, delete heavy
      for (int i = 0; i < SHRINK_ITEMS; i++) random_request(0);

      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests: find %0d, modify %0d, append %0d, delete %0d",
               cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
               cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
      $display("ok %0d, not found %0d, bad index %0d, full %0d; peak list length %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], peak_count);
      if (errors == 0) begin
         $display("tb_array_list_search_edit_unit: PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("tb_array_list_search_edit_unit: FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/alse_pkg.sv
rtl/alse_req_if.sv
rtl/alse_rsp_if.sv
rtl/array_list_search_edit_unit.sv
dv/tb_array_list_search_edit_unit.sv
